// ===== rtl/bkdp_pkg.sv =====
// Package for the base-k digit permuter: widths, codes, FSM state type and
// the command/status structs passed between controller and datapath.
// No dependencies.
`default_nettype none

package bkdp_pkg;

    // Field and datapath widths
    localparam int DATA_W     = 64;
    localparam int RADIX_W    = 5;
    localparam int NUM_W      = 7;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int PROD_W     = DATA_W + RADIX_W;

    // Power table covers every destination a 6-bit entry can name
    localparam int POW_DEPTH  = 64;
    localparam int EXP_W      = 7;

    // Divide by the radix one byte of the dividend per cycle
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = DATA_W / BITS_PER_STEP;
    localparam int DIV_CNT_W     = 3;

    localparam int MIN_RADIX       = 2;
    localparam int MIN_PERM_DIGITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIGITS = 1'b1;

    // Request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_XFORM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_ACC,
        ST_TOP_WAIT,
        ST_TOP_LOAD,
        ST_TOP_MUL,
        ST_DONE
    } bkdp_state_t;

    typedef struct packed {
        logic perm_wr;
        logic load_x;
        logic prep_step;
        logic start;
        logic div_step;
        logic acc;
        logic top_load;
        logic top_mul;
        logic top_add;
        logic out_load;
    } bkdp_cmd_t;

    typedef struct packed {
        logic pow_ok;
        logic prep_last;
        logic n_small;
        logic div_last;
        logic last_digit;
        logic cnt_zero;
    } bkdp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bkdp_dpath.sv =====
// Datapath of the base-k digit permuter: config registers, permutation and
// power tables, byte-serial divider by the radix, shared 64x5 multiplier.
// Depends on bkdp_pkg.
`default_nettype none

module bkdp_dpath #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bkdp_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [bkdp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [bkdp_pkg::POS_W-1:0]         entry_slot,
    input  wire logic [bkdp_pkg::POS_W-1:0]         entry_target,
    input  wire logic [bkdp_pkg::DATA_W-1:0]        labeling,
    input  wire bkdp_pkg::bkdp_cmd_t                cmd,
    output bkdp_pkg::bkdp_sts_t                     sts,
    output logic [bkdp_pkg::DATA_W-1:0]             permuted,
    output logic                                    too_large
);
    import bkdp_pkg::*;

    localparam int SLOT_W = $clog2(MAX_DIGITS);

    // Tables
    logic [POS_W-1:0]  perm_mem [MAX_DIGITS];
    logic [DATA_W-1:0] pow_mem  [POW_DEPTH];

    // Control registers
    logic [RADIX_W-1:0]   radix_reg;
    logic [NUM_W-1:0]     num_digits_reg;
    logic                 pow_ok_reg, pow_ok_next;
    logic [EXP_W-1:0]     e_reg, e_next;
    logic [POS_W-1:0]     p_reg, p_next;
    logic [POS_W-1:0]     top_reg, top_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [POS_W-1:0]     cnt_reg, cnt_next;

    // Payload registers
    logic [DATA_W-1:0]  cur_reg, cur_next;
    logic [DATA_W-1:0]  r_reg, r_next;
    logic [DATA_W-1:0]  wrap_reg, wrap_next;
    logic               sat_reg, sat_next;
    logic [DATA_W-1:0]  lim_reg, lim_next;
    logic               lim_sat_reg, lim_sat_next;
    logic [POS_W-1:0]   p_max_reg, p_max_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic               flag_reg, flag_next;
    logic [DATA_W-1:0]  permuted_reg;
    logic               too_large_reg;
    logic [POS_W-1:0]   perm_rd_reg;
    logic [DATA_W-1:0]  pow_rd_reg;

    logic [RADIX_W-1:0] k_eff;
    logic [NUM_W-1:0]   n_eff;
    logic [NUM_W-1:0]   n_m1;
    logic [NUM_W-1:0]   rd_slot;
    logic [POS_W-1:0]   top_calc;
    logic [DATA_W-1:0]  mul_a;
    logic [RADIX_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [RADIX_W-1:0] div_rem;
    logic [BITS_PER_STEP-1:0] div_q;

    // Clamp the configuration to its working range
    assign k_eff   = (radix_reg < RADIX_W'(MIN_RADIX)) ? RADIX_W'(MIN_RADIX) : radix_reg;
    assign n_eff   = (num_digits_reg > NUM_W'(MAX_DIGITS)) ? NUM_W'(MAX_DIGITS)
                                                           : num_digits_reg;
    assign n_m1    = n_eff - NUM_W'(1);
    assign rd_slot = n_m1 - {1'b0, p_reg};
    assign top_calc = (n_m1[POS_W-1:0] < p_max_reg) ? n_m1[POS_W-1:0] : p_max_reg;

    // Shared multiplier: power build, digit weighting, top-digit scaling
    always_comb
    begin
        if (cmd.prep_step)
        begin
            mul_a = wrap_reg;
            mul_b = k_eff;
        end
        else if (cmd.acc)
        begin
            mul_a = pow_rd_reg;
            mul_b = rem_reg;
        end
        else
        begin
            mul_a = cur_reg;
            mul_b = k_eff;
        end
    end

    assign prod = {{RADIX_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};

    // Divide the top byte of the running value by the radix, bit by bit
    always_comb
    begin
        logic [RADIX_W:0] trial;
        logic [RADIX_W-1:0] rem_v;
        rem_v = rem_reg;
        div_q = '0;
        for (int i = BITS_PER_STEP - 1; i >= 0; i--)
        begin
            trial = {rem_v, cur_reg[DATA_W - BITS_PER_STEP + i]};
            if (trial >= {1'b0, k_eff})
            begin
                trial    = trial - {1'b0, k_eff};
                div_q[i] = 1'b1;
            end
            rem_v = trial[RADIX_W-1:0];
        end
        div_rem = rem_v;
    end

    // Next-state logic for the datapath registers
    always_comb
    begin
        pow_ok_next  = pow_ok_reg;
        e_next       = e_reg;
        p_next       = p_reg;
        top_next     = top_reg;
        div_cnt_next = div_cnt_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        r_next       = r_reg;
        wrap_next    = wrap_reg;
        sat_next     = sat_reg;
        lim_next     = lim_reg;
        lim_sat_next = lim_sat_reg;
        p_max_next   = p_max_reg;
        rem_next     = rem_reg;
        flag_next    = flag_reg;

        if (cmd.load_x)
        begin
            cur_next  = labeling;
            wrap_next = DATA_W'(1);
            sat_next  = 1'b0;
            e_next    = '0;
        end

        // Build k^e: wrapped value to the table, saturated limit for the flag
        if (cmd.prep_step)
        begin
            wrap_next = prod[DATA_W-1:0];
            sat_next  = sat_reg | (prod[PROD_W-1:DATA_W] != '0);
            e_next    = e_reg + EXP_W'(1);
            if (e_reg == n_eff)
            begin
                lim_next     = wrap_reg;
                lim_sat_next = sat_reg;
            end
            if (!sat_reg)
            begin
                p_max_next = e_reg[POS_W-1:0];
            end
            if (sts.prep_last)
            begin
                pow_ok_next = 1'b1;
            end
        end

        if (cmd.start)
        begin
            flag_next    = !lim_sat_reg && (cur_reg >= lim_reg);
            r_next       = sts.n_small ? cur_reg : '0;
            p_next       = '0;
            top_next     = top_calc;
            rem_next     = '0;
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            cur_next     = {cur_reg[DATA_W-BITS_PER_STEP-1:0], div_q};
            rem_next     = div_rem;
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        // Add digit times its weight, advance to the next position
        if (cmd.acc)
        begin
            r_next       = r_reg + prod[DATA_W-1:0];
            rem_next     = '0;
            p_next       = p_reg + POS_W'(1);
            div_cnt_next = '0;
        end

        if (cmd.top_load)
        begin
            cnt_next = perm_rd_reg;
        end

        if (cmd.top_mul)
        begin
            cur_next = prod[DATA_W-1:0];
            cnt_next = cnt_reg - POS_W'(1);
        end

        if (cmd.top_add)
        begin
            r_next = r_reg + cur_reg;
        end

        // Drop the cached powers on any configuration write
        if (cfg_wr_en)
        begin
            pow_ok_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_W'(MIN_RADIX);
            num_digits_reg <= NUM_W'(1);
            pow_ok_reg     <= 1'b0;
            e_reg          <= '0;
            p_reg          <= '0;
            top_reg        <= '0;
            div_cnt_reg    <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_addr == REG_RADIX))
            begin
                radix_reg <= cfg_wdata[RADIX_W-1:0];
            end
            if (cfg_wr_en && (cfg_addr == REG_NUM_DIGITS))
            begin
                num_digits_reg <= cfg_wdata[NUM_W-1:0];
            end
            pow_ok_reg  <= pow_ok_next;
            e_reg       <= e_next;
            p_reg       <= p_next;
            top_reg     <= top_next;
            div_cnt_reg <= div_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        r_reg       <= r_next;
        wrap_reg    <= wrap_next;
        sat_reg     <= sat_next;
        lim_reg     <= lim_next;
        lim_sat_reg <= lim_sat_next;
        p_max_reg   <= p_max_next;
        rem_reg     <= rem_next;
        flag_reg    <= flag_next;
        if (cmd.out_load)
        begin
            permuted_reg  <= r_reg;
            too_large_reg <= flag_reg;
        end
    end

    // Permutation table: write on load transfer, registered read of the current slot
    always_ff @(posedge clk)
    begin
        if (cmd.perm_wr && ({1'b0, entry_slot} < NUM_W'(MAX_DIGITS)))
        begin
            perm_mem[entry_slot[SLOT_W-1:0]] <= entry_target;
        end
        perm_rd_reg <= perm_mem[rd_slot[SLOT_W-1:0]];
    end

    // Power table: filled during preparation, read at the looked-up destination
    always_ff @(posedge clk)
    begin
        if (cmd.prep_step && !e_reg[EXP_W-1])
        begin
            pow_mem[e_reg[EXP_W-2:0]] <= wrap_reg;
        end
        pow_rd_reg <= pow_mem[perm_rd_reg];
    end

    // Status to the controller
    always_comb
    begin
        sts.pow_ok     = pow_ok_reg;
        sts.prep_last  = (e_reg == EXP_W'(POW_DEPTH));
        sts.n_small    = (n_eff < NUM_W'(MIN_PERM_DIGITS));
        sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.last_digit = ((p_reg + POS_W'(1)) == top_reg);
        sts.cnt_zero   = (cnt_reg == '0);
    end

    assign permuted  = permuted_reg;
    assign too_large = too_large_reg;

endmodule

`default_nettype wire

// ===== rtl/bkdp_ctrl.sv =====
// Controller of the base-k digit permuter: request/response handshakes and
// the sequencing FSM that issues commands to the datapath.
// Depends on bkdp_pkg.
`default_nettype none

module bkdp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic                 req_type,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    input  wire bkdp_pkg::bkdp_sts_t  sts,
    output bkdp_pkg::bkdp_cmd_t       cmd
);
    import bkdp_pkg::*;

    bkdp_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        req_xfer;
    logic        out_free;

    // Take requests only while idle
    assign req_stall = (state_reg != ST_IDLE);

    assign req_xfer = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req_type == REQ_XFORM))
                begin
                    state_next = sts.pow_ok ? ST_START : ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.prep_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = sts.n_small ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = sts.last_digit ? ST_TOP_WAIT : ST_DIV;
            end
            ST_TOP_WAIT:
            begin
                state_next = ST_TOP_LOAD;
            end
            ST_TOP_LOAD:
            begin
                state_next = ST_TOP_MUL;
            end
            ST_TOP_MUL:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.perm_wr  = req_xfer && (req_type == REQ_LOAD);
                cmd.load_x   = req_xfer && (req_type == REQ_XFORM);
            end
            ST_PREP:
            begin
                cmd.prep_step = 1'b1;
            end
            ST_START:
            begin
                cmd.start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_TOP_WAIT:
            begin
                cmd = '0;
            end
            ST_TOP_LOAD:
            begin
                cmd.top_load = 1'b1;
            end
            ST_TOP_MUL:
            begin
                cmd.top_mul = !sts.cnt_zero;
                cmd.top_add = sts.cnt_zero;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until its transfer, refill when a new one is ready
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/base_k_digit_permuter_top.sv =====
// Top level of the base-k digit permuter: controller plus datapath.
// Depends on bkdp_pkg, bkdp_ctrl, bkdp_dpath.
//
//   channel   handshake             payload
//   -------   -------------------   ----------------------------------------
//   request   req_valid/req_stall   req_type, entry_slot, entry_target, labeling
//   response  rsp_valid/rsp_stall   permuted, too_large
//   config    cfg_wr_en             cfg_addr, cfg_wdata
//
// A table load gives no response. A transform below two digits passes the
// labeling through; otherwise each digit under the top one takes a byte-wise
// divide by the radix and one multiply-accumulate, then the top digit is
// scaled by repeated multiply by the radix, as many times as its destination.
// The first transform after reset or a config write builds the power table.
// Reset clears config to radix 2, one digit; the permutation table is
// undefined until loaded. One transform is in flight at a time; a finished
// result waits in the output register while the next request is taken.
`default_nettype none

module base_k_digit_permuter_top #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bkdp_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [bkdp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic                               req_type,
    input  wire logic [bkdp_pkg::POS_W-1:0]         entry_slot,
    input  wire logic [bkdp_pkg::POS_W-1:0]         entry_target,
    input  wire logic [bkdp_pkg::DATA_W-1:0]        labeling,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic [bkdp_pkg::DATA_W-1:0]             permuted,
    output logic                                    too_large
);
    import bkdp_pkg::*;

    bkdp_cmd_t cmd;
    bkdp_sts_t sts;

    // Sequencer
    bkdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Tables, divider and accumulator
    bkdp_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .entry_slot   (entry_slot),
        .entry_target (entry_target),
        .labeling     (labeling),
        .cmd          (cmd),
        .sts          (sts),
        .permuted     (permuted),
        .too_large    (too_large)
    );

endmodule

`default_nettype wire

// ===== tb/base_k_digit_permuter_top_tb.sv =====
// Testbench for base_k_digit_permuter_top: directed rows, then random traffic over
// a list of radix/digit-count settings, checked against a digit-permutation predictor.
// Depends on bkdp_pkg and the base_k_digit_permuter_top RTL.
`timescale 1ns / 100ps

module base_k_digit_permuter_top_tb;

    import bkdp_pkg::*;

    localparam int          MAX_DIGITS     = 64;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          HOLD_AT        = 300;
    localparam int          PAUSE_AT       = 1000;
    localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] permuted;
        logic        too_large;
    } perm_result_t;

    typedef enum logic [1:0] {DIR_CFG, DIR_LOAD, DIR_XFORM} dir_kind_t;

    typedef struct {
        dir_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [POS_W-1:0]      slot;
        logic [POS_W-1:0]      target;
        logic [63:0]           lab;
        bit                    typed;
        logic [63:0]           exp_perm;
        bit                    exp_flag;
    } dir_row_t;

    typedef struct {
        int radix;
        int digits;
        int count;
    } setting_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  req_valid;
    logic                  req_stall;
    logic                  req_type;
    logic [POS_W-1:0]      entry_slot;
    logic [POS_W-1:0]      entry_target;
    logic [DATA_W-1:0]     labeling;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [DATA_W-1:0]     permuted;
    logic                  too_large;

    // Side channel that travels with each request: a hand-typed expectation
    logic                  typed_row;
    logic [63:0]           typed_perm;
    logic                  typed_flag;

    // Mirror of the block's state
    logic [RADIX_W-1:0]    radix_reg;
    logic [NUM_W-1:0]      ndig_reg;
    logic [POS_W-1:0]      dest_of_slot [MAX_DIGITS];

    perm_result_t          expected_perms [$];

    int                    errors;
    int                    loads_seen;
    int                    xforms_seen;
    int                    settings_done;
    int                    idle_cycles;
    int                    rand_sent;
    int                    send_idle_pct;
    int                    rcv_idle_pct;
    logic                  hold_req;
    bit                    hold_done;
    int                    hold_count;

    dir_row_t              dir_rows [29];
    setting_t              plan [12];

    base_k_digit_permuter_top #(.MAX_DIGITS(MAX_DIGITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .entry_slot   (entry_slot),
        .entry_target (entry_target),
        .labeling     (labeling),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .permuted     (permuted),
        .too_large    (too_large)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // base^e; returns 1 when the power reaches 2^64
    function automatic bit pow_saturating(input logic [63:0] base, input int unsigned e,
                                          output logic [63:0] val);
        logic [63:0] acc;
        int unsigned i;
        acc = 64'd1;
        val = 64'd0;
        for (i = 0; i < e; i++)
        begin
            if (acc > ALL_ONES / base)
                return 1'b1;
            acc = acc * base;
        end
        val = acc;
        return 1'b0;
    endfunction

    // base^e wrapped to 64 bits
    function automatic logic [63:0] pow_mod64(input logic [63:0] base, input int unsigned e);
        logic [63:0] acc;
        int unsigned i;
        acc = 64'd1;
        for (i = 0; i < e; i++)
            acc = acc * base;
        return acc;
    endfunction

    // Split the labeling into base-k digits, top digit first, and re-weight each
    // by k^destination from the slot table; flag inputs at or above k^n.
    function automatic perm_result_t permute_digits(input logic [63:0] lab);
        perm_result_t r;
        logic [63:0]  k;
        logic [63:0]  lim;
        logic [63:0]  wt;
        logic [63:0]  rest;
        logic [63:0]  digit;
        int unsigned  n;
        int unsigned  s;
        k = (radix_reg < MIN_RADIX) ? 64'(MIN_RADIX) : 64'(radix_reg);
        n = (ndig_reg > MAX_DIGITS) ? MAX_DIGITS : ndig_reg;
        r.too_large = pow_saturating(k, n, lim) ? 1'b0 : (lab >= lim);
        if (n < MIN_PERM_DIGITS)
            r.permuted = lab;
        else
        begin
            r.permuted = 64'd0;
            rest = lab;
            for (s = 0; s < n; s++)
            begin
                // positions worth 2^64 or more hold a zero digit
                if (!pow_saturating(k, n - 1 - s, wt))
                begin
                    digit = rest / wt;
                    rest  = rest % wt;
                    r.permuted = r.permuted + digit * pow_mod64(k, dest_of_slot[s]);
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Bus monitor: track config writes, predict on request transfers,
    // check response transfers, and watch for a stuck block.
    always @(posedge clk)
    begin
        perm_result_t exp_r;
        perm_result_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_perms.size() == 0)
                    flag_mismatch("response with nothing pending", permuted, 64'd0);
                else
                begin
                    exp_r = expected_perms.pop_front();
                    if (permuted !== exp_r.permuted)
                        flag_mismatch("permuted", permuted, exp_r.permuted);
                    if (too_large !== exp_r.too_large)
                        flag_mismatch("too_large", 64'(too_large), 64'(exp_r.too_large));
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_addr == REG_RADIX)
                    radix_reg = cfg_wdata[RADIX_W-1:0];
                else if (cfg_addr == REG_NUM_DIGITS)
                    ndig_reg = cfg_wdata[NUM_W-1:0];
            end
            if (req_valid && !req_stall)
            begin
                if (req_type == REQ_LOAD)
                begin
                    dest_of_slot[entry_slot] = entry_target;
                    loads_seen++;
                end
                else
                begin
                    if (typed_row)
                    begin
                        want.permuted  = typed_perm;
                        want.too_large = typed_flag;
                    end
                    else
                        want = permute_digits(labeling);
                    expected_perms.insert(expected_perms.size(), want);
                    xforms_seen++;
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            rsp_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Offer one request and hold it until the transfer; valid stays high on return
    task automatic send_request(input logic rtype, input logic [POS_W-1:0] slot,
                                input logic [POS_W-1:0] target, input logic [63:0] lab,
                                input bit typed, input logic [63:0] ep, input bit ef);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_type     <= rtype;
        entry_slot   <= slot;
        entry_target <= target;
        labeling     <= lab;
        typed_row    <= typed;
        typed_perm   <= ep;
        typed_flag   <= ef;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Drop valid and wait until every pending result is back, then let the block settle
    task automatic drain_block(input int settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_perms.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        drain_block(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_done++;
    endtask

    initial
    begin
        int          p;
        int          item;
        int          i;
        int          j;
        int          tmp;
        int          n_eff;
        int          n_fill;
        int          order [MAX_DIGITS];
        logic [63:0] k_eff;
        logic [63:0] lim_val;
        logic [63:0] rnd;
        logic [63:0] lab;
        bit          lim_ok;

        // Drive every input to a known value before the first edge
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_RADIX;
        cfg_wdata    = '0;
        req_valid    = 1'b0;
        req_type     = REQ_LOAD;
        entry_slot   = '0;
        entry_target = '0;
        labeling     = '0;
        rsp_stall    = 1'b0;
        typed_row    = 1'b0;
        typed_perm   = '0;
        typed_flag   = 1'b0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        hold_count   = 0;
        errors       = 0;
        loads_seen   = 0;
        xforms_seen  = 0;
        settings_done = 0;
        idle_cycles  = 0;
        rand_sent    = 0;
        send_idle_pct = 23;
        rcv_idle_pct  = 66;
        radix_reg    = RADIX_W'(2);
        ndig_reg     = NUM_W'(1);
        foreach (dest_of_slot[s])
            dest_of_slot[s] = '0;

        // Directed rows: pass-through at reset, swaps, far destinations, radix clamps
        dir_rows = '{
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd0, 1'b1, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd1, 1'b1, 64'd1, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd2, 1'b1, 64'd2, 1'b1},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, ALL_ONES, 1'b1, ALL_ONES, 1'b1},
            '{DIR_LOAD, REG_RADIX, 7'd0, 6'd0, 6'd1, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_LOAD, REG_RADIX, 7'd0, 6'd1, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_LOAD, REG_RADIX, 7'd0, 6'd63, 6'd63, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, REG_NUM_DIGITS, 7'd2, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd1, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd3, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd4, 1'b0, 64'd0, 1'b0},
            '{DIR_LOAD, REG_RADIX, 7'd0, 6'd0, 6'd63, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd2, 1'b0, 64'd0, 1'b0},
            '{DIR_LOAD, REG_RADIX, 7'd0, 6'd0, 6'd1, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, REG_NUM_DIGITS, 7'd0, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd0, 1'b1, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd5, 1'b1, 64'd5, 1'b1},
            '{DIR_CFG, REG_RADIX, 7'd31, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, REG_NUM_DIGITS, 7'd1, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd30, 1'b1, 64'd30, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd31, 1'b1, 64'd31, 1'b1},
            '{DIR_CFG, REG_RADIX, 7'd1, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'd2, 1'b1, 64'd2, 1'b1},
            '{DIR_CFG, REG_RADIX, 7'd16, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, REG_NUM_DIGITS, 7'd2, 6'd0, 6'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'h12, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'hFF, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, 64'h100, 1'b0, 64'd0, 1'b0},
            '{DIR_XFORM, REG_RADIX, 7'd0, 6'd0, 6'd0, ALL_ONES, 1'b0, 64'd0, 1'b0}
        };

        // Random settings: extremes of both registers, clamped and saturated values.
        // The 64-digit settings are slow, so they get fewer items.
        plan = '{
            '{2, 2, 200}, '{3, 5, 250}, '{16, 16, 200}, '{31, 12, 200},
            '{0, 6, 200}, '{10, 127, 100}, '{1, 0, 150}, '{2, 64, 120},
            '{7, 20, 200}, '{16, 64, 100}, '{4, 1, 150}, '{5, 3, 250}
        };

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (dir_rows[r])
        begin
            case (dir_rows[r].kind)
                DIR_CFG:
                    write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
                DIR_LOAD:
                    send_request(REQ_LOAD, dir_rows[r].slot, dir_rows[r].target, 64'd0,
                                 1'b0, 64'd0, 1'b0);
                default:
                    send_request(REQ_XFORM, '0, '0, dir_rows[r].lab, dir_rows[r].typed,
                                 dir_rows[r].exp_perm, dir_rows[r].exp_flag);
            endcase
        end

        // Random traffic: per setting, load a fresh permutation, then mix loads
        // and transforms with labels around the k^n limit
        for (p = 0; p < $size(plan); p++)
        begin
            write_reg(REG_RADIX, plan[p].radix);
            write_reg(REG_NUM_DIGITS, plan[p].digits);
            n_eff  = (plan[p].digits > MAX_DIGITS) ? MAX_DIGITS : plan[p].digits;
            n_fill = (n_eff >= MIN_PERM_DIGITS) ? n_eff : 0;
            k_eff  = (plan[p].radix < MIN_RADIX) ? 64'(MIN_RADIX) : 64'(plan[p].radix);
            lim_ok = !pow_saturating(k_eff, n_eff, lim_val);
            for (i = 0; i < n_fill; i++)
                order[i] = i;
            for (i = n_fill - 1; i > 0; i--)
            begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end

            for (item = 0; item < plan[p].count; item++)
            begin
                // Receiver idles most first, then the sender, then neither
                if (rand_sent < 700)
                begin
                    send_idle_pct = 23;
                    rcv_idle_pct  = 66;
                end
                else if (rand_sent < 1400)
                begin
                    send_idle_pct = 66;
                    rcv_idle_pct  = 23;
                end
                else
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
                if (rand_sent == HOLD_AT)
                    hold_req <= 1'b1;
                if (rand_sent == PAUSE_AT)
                    drain_block(0);

                if (item < n_fill)
                    send_request(REQ_LOAD, POS_W'(item), POS_W'(order[item]), 64'd0,
                                 1'b0, 64'd0, 1'b0);
                else if ($urandom_range(3) == 0)
                    send_request(REQ_LOAD, POS_W'($urandom_range(63)),
                                 ($urandom_range(1) && n_eff > 0) ?
                                     POS_W'($urandom_range(n_eff - 1)) :
                                     POS_W'($urandom_range(63)),
                                 64'd0, 1'b0, 64'd0, 1'b0);
                else
                begin
                    rnd = {$urandom, $urandom};
                    case ($urandom_range(3))
                        0: lab = rnd;
                        1: lab = lim_ok ? rnd % lim_val : rnd;
                        2: lab = lim_ok ? lim_val - 64'($urandom_range(1)) : ALL_ONES;
                        default: lab = 64'($urandom_range(255));
                    endcase
                    send_request(REQ_XFORM, POS_W'($urandom_range(63)),
                                 POS_W'($urandom_range(63)), lab, 1'b0, 64'd0, 1'b0);
                end
                rand_sent++;
            end
        end

        // Let every result come back and the block go quiet
        drain_block(TAIL_CYCLES);

        $display("Covered %0d table loads and %0d transforms over %0d register writes,",
                 loads_seen, xforms_seen, settings_done);
        $display("including radix and digit-count clamps, saturated limits and a long hold-off");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
